### design/ppmdec_pkg.sv
// ppmdec_pkg: shared types, constants and helpers of the ppm p6 stream decoder
// used by ppmdec_luma and ppm_p6_stream_decoder_core, depends on nothing
package ppmdec_pkg;

	// image geometry accepted by the decoder (square images only)
	localparam int unsigned IMAGE_SIDE  = 64;
	localparam int unsigned PIXEL_TOTAL = IMAGE_SIDE * IMAGE_SIDE;
	localparam int unsigned INDEX_W     = 12;
	localparam int unsigned PIX_CNT_W   =
		($clog2(PIXEL_TOTAL) > INDEX_W) ? $clog2(PIXEL_TOTAL) : INDEX_W;

	localparam int unsigned NUM_W = 16;
	localparam logic [NUM_W-1:0] NUM_MAX    = '1;
	localparam logic [NUM_W-1:0] MAXVAL_REQ = NUM_W'(255);
	localparam logic [NUM_W-1:0] SIDE_REQ   = NUM_W'(IMAGE_SIDE);

	localparam logic [7:0] CHAR_P    = 8'h50;
	localparam logic [7:0] CHAR_6    = 8'h36;
	localparam logic [7:0] CHAR_HASH = 8'h23;
	localparam logic [7:0] CHAR_LF   = 8'h0A;
	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_NINE = 8'h39;
	localparam logic [7:0] CHAR_SP   = 8'h20;
	localparam logic [7:0] CHAR_TAB  = 8'h09;
	localparam logic [7:0] CHAR_CR   = 8'h0D;

	// bt.601 weights in 16-bit fixed point, sum of weights is exactly 65536
	localparam int unsigned LUMA_SUM_W = 25;
	localparam logic [15:0] LUMA_W_R   = 16'd19595;
	localparam logic [15:0] LUMA_W_G   = 16'd38470;
	localparam logic [15:0] LUMA_W_B   = 16'd7471;
	localparam logic [15:0] LUMA_ROUND = 16'd32768;

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_MAGIC2,
		PH_SKIP,
		PH_NUM,
		PH_PIXELS,
		PH_DONE,
		PH_DEAD
	} phase_t;

	typedef enum logic [2:0] {
		ST_PIXEL,
		ST_MAGIC,
		ST_MALFORMED,
		ST_NOSEP,
		ST_SIZE,
		ST_TRUNC
	} status_t;

	function automatic logic is_ws(input logic [7:0] b);
		return (b == CHAR_SP) || ((b >= CHAR_TAB) && (b <= CHAR_CR));
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return (b >= CHAR_ZERO) && (b <= CHAR_NINE);
	endfunction

endpackage

### design/ppmdec_luma.sv
// ppmdec_luma: rounded and clamped bt.601 luma of one rgb pixel
// depends on ppmdec_pkg for the fixed-point weights
module ppmdec_luma (
	input  logic [7:0] red,
	input  logic [7:0] green,
	input  logic [7:0] blue,
	output logic [7:0] luma
);

	localparam int unsigned SW = ppmdec_pkg::LUMA_SUM_W;

	logic [SW-1:0] sum;

	assign sum = SW'(red)   * SW'(ppmdec_pkg::LUMA_W_R)
	           + SW'(green) * SW'(ppmdec_pkg::LUMA_W_G)
	           + SW'(blue)  * SW'(ppmdec_pkg::LUMA_W_B)
	           + SW'(ppmdec_pkg::LUMA_ROUND);

	// integer part above 255 saturates
	assign luma = (sum[SW-1:16] > (SW-16)'(255)) ? 8'hFF : sum[23:16];

endmodule

### design/ppm_p6_stream_decoder_core.sv
// ppm_p6_stream_decoder_core: top level of the ppm p6 byte-stream decoder
// depends on ppmdec_pkg and ppmdec_luma
//
// Takes one file byte per request and gives at most one result per byte: a pixel
// (status 0) with its rgb, luma, raster index and last flag, or one error code.
// One byte is accepted every cycle while in_stall is low; a request is registered on entry and
// parsed from the entry register, and its result is loaded into the output register when the
// byte leaves the entry register. in_stall
// rises only when the byte in the entry register makes a result while the output
// register still holds one that is stalled. The header must give a width and height
// of IMAGE_SIDE and a maxval of 255; after an error the bytes are dropped until the
// next start of file.
module ppm_p6_stream_decoder_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        start_of_file,
	input  logic        end_of_file,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic [7:0]  luma,
	output logic [11:0] pixel_index,
	output logic        last_pixel
);

	localparam int unsigned CW = ppmdec_pkg::PIX_CNT_W;
	localparam int unsigned NW = ppmdec_pkg::NUM_W;
	localparam int unsigned AW = NW + 4;

	// entry register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       sof_s1;
	logic       eof_s1;

	// parser state
	ppmdec_pkg::phase_t phase_q, phase_d;
	logic [1:0]    token_q, token_d;
	logic          comment_q, comment_d;
	logic [NW-1:0] acc_q, acc_d;
	logic [NW-1:0] width_q, width_d;
	logic [NW-1:0] height_q, height_d;
	logic [1:0]    slot_q, slot_d;
	logic [7:0]    red_q, red_d;
	logic [7:0]    green_q, green_d;
	logic [CW-1:0] cnt_q, cnt_d;

	// result register
	logic                out_valid_q;
	ppmdec_pkg::status_t status_q;
	logic [7:0]          red_out_q;
	logic [7:0]          green_out_q;
	logic [7:0]          blue_out_q;
	logic [7:0]          luma_out_q;
	logic [11:0]         index_out_q;
	logic                last_out_q;

	logic                res_valid;
	ppmdec_pkg::status_t res_status;
	logic                adv_s1;
	logic                out_free;
	logic                b_ws;
	logic                b_digit;
	logic                b_hash;
	logic [3:0]          digit_val;
	logic [AW-1:0]       acc_x10;
	logic [NW-1:0]       acc_sat;
	logic                size_bad;
	logic                last_hit;
	logic [7:0]          luma_val;

	assign b_ws      = ppmdec_pkg::is_ws(byte_s1);
	assign b_digit   = ppmdec_pkg::is_digit(byte_s1);
	assign b_hash    = (byte_s1 == ppmdec_pkg::CHAR_HASH);
	assign digit_val = 4'(byte_s1 - ppmdec_pkg::CHAR_ZERO);
	assign acc_x10   = AW'(acc_q) * AW'(10) + AW'(digit_val);
	assign acc_sat   = (acc_x10 > AW'(ppmdec_pkg::NUM_MAX)) ? ppmdec_pkg::NUM_MAX
	                                                       : acc_x10[NW-1:0];
	assign size_bad  = (width_q != ppmdec_pkg::SIDE_REQ) ||
	                   (height_q != ppmdec_pkg::SIDE_REQ) ||
	                   (acc_q != ppmdec_pkg::MAXVAL_REQ);
	assign last_hit  = (cnt_q == CW'(ppmdec_pkg::PIXEL_TOTAL - 1));

	ppmdec_luma u_luma (
		.red   (red_q),
		.green (green_q),
		.blue  (byte_s1),
		.luma  (luma_val)
	);

	// next parser state
	always_comb begin
		phase_d   = phase_q;
		token_d   = token_q;
		comment_d = comment_q;
		acc_d     = acc_q;
		width_d   = width_q;
		height_d  = height_q;
		slot_d    = slot_q;
		red_d     = red_q;
		green_d   = green_q;
		cnt_d     = cnt_q;
		if (eof_s1) begin
			phase_d = ppmdec_pkg::PH_IDLE;
		end else if (sof_s1) begin
			token_d   = '0;
			comment_d = 1'b0;
			acc_d     = '0;
			width_d   = '0;
			height_d  = '0;
			slot_d    = '0;
			red_d     = '0;
			green_d   = '0;
			cnt_d     = '0;
			phase_d   = (byte_s1 == ppmdec_pkg::CHAR_P) ? ppmdec_pkg::PH_MAGIC2
			                                            : ppmdec_pkg::PH_DEAD;
		end else begin
			case (phase_q)
				ppmdec_pkg::PH_MAGIC2: begin
					phase_d = (byte_s1 == ppmdec_pkg::CHAR_6) ? ppmdec_pkg::PH_SKIP
					                                          : ppmdec_pkg::PH_DEAD;
				end
				ppmdec_pkg::PH_SKIP: begin
					if (comment_q) begin
						if (byte_s1 == ppmdec_pkg::CHAR_LF) comment_d = 1'b0;
					end else if (b_ws) begin
						phase_d = ppmdec_pkg::PH_SKIP;
					end else if (b_hash) begin
						comment_d = 1'b1;
					end else if (b_digit) begin
						acc_d   = NW'(digit_val);
						phase_d = ppmdec_pkg::PH_NUM;
					end else begin
						phase_d = ppmdec_pkg::PH_DEAD;
					end
				end
				ppmdec_pkg::PH_NUM: begin
					if (b_digit) begin
						acc_d = acc_sat;
					end else if (token_q < 2'd2) begin
						if (token_q == 2'd0) width_d = acc_q;
						else height_d = acc_q;
						token_d = token_q + 2'd1;
						// the ending byte is handled as a skipped byte
						if (b_ws) phase_d = ppmdec_pkg::PH_SKIP;
						else if (b_hash) begin
							phase_d   = ppmdec_pkg::PH_SKIP;
							comment_d = 1'b1;
						end else phase_d = ppmdec_pkg::PH_DEAD;
					end else if (!b_ws || size_bad) begin
						phase_d = ppmdec_pkg::PH_DEAD;
					end else begin
						phase_d = ppmdec_pkg::PH_PIXELS;
						slot_d  = '0;
						cnt_d   = '0;
					end
				end
				ppmdec_pkg::PH_PIXELS: begin
					case (slot_q)
						2'd0: begin
							red_d  = byte_s1;
							slot_d = 2'd1;
						end
						2'd1: begin
							green_d = byte_s1;
							slot_d  = 2'd2;
						end
						default: begin
							slot_d = 2'd0;
							cnt_d  = cnt_q + CW'(1);
							if (last_hit) phase_d = ppmdec_pkg::PH_DONE;
						end
					endcase
				end
				default: phase_d = phase_q;
			endcase
		end
	end

	// result of the byte in the entry register
	always_comb begin
		res_valid  = 1'b0;
		res_status = ppmdec_pkg::ST_PIXEL;
		if (eof_s1) begin
			res_valid  = phase_q inside {ppmdec_pkg::PH_MAGIC2, ppmdec_pkg::PH_SKIP,
			                             ppmdec_pkg::PH_NUM, ppmdec_pkg::PH_PIXELS};
			res_status = ppmdec_pkg::ST_TRUNC;
		end else if (sof_s1) begin
			res_valid  = (byte_s1 != ppmdec_pkg::CHAR_P);
			res_status = ppmdec_pkg::ST_MAGIC;
		end else begin
			case (phase_q)
				ppmdec_pkg::PH_MAGIC2: begin
					res_valid  = (byte_s1 != ppmdec_pkg::CHAR_6);
					res_status = ppmdec_pkg::ST_MAGIC;
				end
				ppmdec_pkg::PH_SKIP: begin
					res_valid  = !comment_q && !b_ws && !b_hash && !b_digit;
					res_status = ppmdec_pkg::ST_MALFORMED;
				end
				ppmdec_pkg::PH_NUM: begin
					if (b_digit) begin
						res_valid = 1'b0;
					end else if (token_q < 2'd2) begin
						res_valid  = !b_ws && !b_hash;
						res_status = ppmdec_pkg::ST_MALFORMED;
					end else if (!b_ws) begin
						res_valid  = 1'b1;
						res_status = ppmdec_pkg::ST_NOSEP;
					end else begin
						res_valid  = size_bad;
						res_status = ppmdec_pkg::ST_SIZE;
					end
				end
				ppmdec_pkg::PH_PIXELS: begin
					res_valid  = (slot_q >= 2'd2);
					res_status = ppmdec_pkg::ST_PIXEL;
				end
				default: res_valid = 1'b0;
			endcase
		end
	end

	// a byte with no result leaves the entry register even when the output is held
	assign out_free = !out_valid_q || !out_stall;
	assign adv_s1   = valid_s1 && (out_free || !res_valid);
	assign in_stall = valid_s1 && !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= data_byte;
			sof_s1  <= start_of_file;
			eof_s1  <= end_of_file;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= ppmdec_pkg::PH_IDLE;
			token_q   <= '0;
			comment_q <= 1'b0;
			acc_q     <= '0;
			width_q   <= '0;
			height_q  <= '0;
			slot_q    <= '0;
			red_q     <= '0;
			green_q   <= '0;
			cnt_q     <= '0;
		end else if (adv_s1) begin
			phase_q   <= phase_d;
			token_q   <= token_d;
			comment_q <= comment_d;
			acc_q     <= acc_d;
			width_q   <= width_d;
			height_q  <= height_d;
			slot_q    <= slot_d;
			red_q     <= red_d;
			green_q   <= green_d;
			cnt_q     <= cnt_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && res_valid) begin
			status_q <= res_status;
			if (res_status == ppmdec_pkg::ST_PIXEL) begin
				red_out_q   <= red_q;
				green_out_q <= green_q;
				blue_out_q  <= byte_s1;
				luma_out_q  <= luma_val;
				index_out_q <= cnt_q[11:0];
				last_out_q  <= last_hit;
			end else begin
				red_out_q   <= '0;
				green_out_q <= '0;
				blue_out_q  <= '0;
				luma_out_q  <= '0;
				index_out_q <= '0;
				last_out_q  <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign red         = red_out_q;
	assign green       = green_out_q;
	assign blue        = blue_out_q;
	assign luma        = luma_out_q;
	assign pixel_index = index_out_q;
	assign last_pixel  = last_out_q;

endmodule

### test/ppm_p6_stream_decoder_core_tb.sv
// ppm_p6_stream_decoder_core_tb: self-checking testbench of the ppm p6 stream decoder
// drives random and hand-built files, predicts every pixel and error code and checks them
// depends on ppmdec_pkg and the ppm_p6_stream_decoder_core rtl
module ppm_p6_stream_decoder_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ppmdec_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 1_000_000;
	localparam int unsigned RANDOM_ITEMS = 500;
	localparam int unsigned LONG_HOLD    = 200;
	localparam int unsigned MAX_REPORTS  = 10;

	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [7:0]  luma;
		logic [11:0] index;
		logic        last;
	} decoded_t;

	typedef enum {RX_FREE, RX_COIN, RX_BUSY} rx_mode_t;
	typedef enum {FK_GOOD, FK_SIZE, FK_NOSEP, FK_CORRUPT, FK_CUT, FK_NOISE} file_kind_t;
	typedef enum {TAIL_EOF, TAIL_NONE, TAIL_EOF_SOF, TAIL_STRAY} tail_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte = 8'h00;
	logic        start_of_file = 1'b0;
	logic        end_of_file = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  status;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic [7:0]  luma;
	logic [11:0] pixel_index;
	logic        last_pixel;

	ppm_p6_stream_decoder_core u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.data_byte(data_byte),
		.start_of_file(start_of_file),
		.end_of_file(end_of_file),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.red(red),
		.green(green),
		.blue(blue),
		.luma(luma),
		.pixel_index(pixel_index),
		.last_pixel(last_pixel)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// decoder state as the predictor sees it
	phase_t      dec_phase;
	logic [1:0]  token_idx;
	logic        in_remark;
	logic [15:0] acc_num;
	logic [15:0] width_seen;
	logic [15:0] height_seen;
	logic [1:0]  rgb_slot;
	logic [7:0]  red_held;
	logic [7:0]  green_held;
	int unsigned pixels_done;
	decoded_t    predicted;

	decoded_t    pending_results[$];
	logic [7:0]  file_buf[$];

	int unsigned cycle_count = 0;
	int unsigned mismatch_count = 0;
	int unsigned requests_sent = 0;
	int unsigned live_items = 0;
	int unsigned files_sent = 0;
	int unsigned input_held = 0;
	int unsigned status_seen[6];
	int unsigned burst_left = 0;
	bit          sender_steady = 1'b0;
	bit          long_hold_req = 1'b0;

	function automatic bit blank_char(input logic [7:0] c);
		return (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
	endfunction

	function automatic bit decimal_char(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic void clear_header();
		token_idx = '0;
		in_remark = 1'b0;
		acc_num = '0;
		width_seen = '0;
		height_seen = '0;
		rgb_slot = '0;
		red_held = '0;
		green_held = '0;
		pixels_done = 0;
	endfunction

	function automatic bit abort_file(input status_t code);
		predicted.status = code;
		dec_phase = PH_DEAD;
		return 1'b1;
	endfunction

	// byte seen between header numbers
	function automatic bit header_gap(input logic [7:0] d);
		if (in_remark) begin
			if (d == CHAR_LF)
				in_remark = 1'b0;
			return 1'b0;
		end
		if (blank_char(d))
			return 1'b0;
		if (d == CHAR_HASH) begin
			in_remark = 1'b1;
			return 1'b0;
		end
		if (decimal_char(d)) begin
			acc_num = 16'(d - CHAR_ZERO);
			dec_phase = PH_NUM;
			return 1'b0;
		end
		return abort_file(ST_MALFORMED);
	endfunction

	// returns 1 when the request makes a result, left in predicted
	function automatic bit decode_byte(input logic [7:0] d, input logic sof, input logic eof);
		phase_t      was;
		int unsigned wide;
		bit          final_pix;
		predicted = '0;
		if (eof) begin
			was = dec_phase;
			dec_phase = PH_IDLE;
			if (was == PH_MAGIC2 || was == PH_SKIP || was == PH_NUM || was == PH_PIXELS) begin
				predicted.status = ST_TRUNC;
				return 1'b1;
			end
			return 1'b0;
		end
		if (sof) begin
			clear_header();
			if (d != CHAR_P)
				return abort_file(ST_MAGIC);
			dec_phase = PH_MAGIC2;
			return 1'b0;
		end
		case (dec_phase)
			PH_MAGIC2: begin
				if (d != CHAR_6)
					return abort_file(ST_MAGIC);
				dec_phase = PH_SKIP;
				return 1'b0;
			end
			PH_SKIP:
				return header_gap(d);
			PH_NUM: begin
				if (decimal_char(d)) begin
					wide = acc_num * 10 + (d - CHAR_ZERO);
					acc_num = (wide > 65535) ? 16'hFFFF : wide[15:0];
					return 1'b0;
				end
				if (token_idx < 2) begin
					if (token_idx == 0)
						width_seen = acc_num;
					else
						height_seen = acc_num;
					token_idx++;
					dec_phase = PH_SKIP;
					return header_gap(d);
				end
				if (!blank_char(d))
					return abort_file(ST_NOSEP);
				if (width_seen != 16'(IMAGE_SIDE) || height_seen != 16'(IMAGE_SIDE) ||
						acc_num != 16'd255)
					return abort_file(ST_SIZE);
				dec_phase = PH_PIXELS;
				rgb_slot = '0;
				pixels_done = 0;
				return 1'b0;
			end
			PH_PIXELS: begin
				if (rgb_slot == 0) begin
					red_held = d;
					rgb_slot = 2'd1;
					return 1'b0;
				end
				if (rgb_slot == 1) begin
					green_held = d;
					rgb_slot = 2'd2;
					return 1'b0;
				end
				wide = (19595 * red_held + 38470 * green_held + 7471 * d + 32768) >> 16;
				final_pix = (pixels_done + 1 >= IMAGE_SIDE * IMAGE_SIDE);
				predicted.status = ST_PIXEL;
				predicted.red = red_held;
				predicted.green = green_held;
				predicted.blue = d;
				predicted.luma = (wide > 255) ? 8'd255 : wide[7:0];
				predicted.index = pixels_done[11:0];
				predicted.last = final_pix;
				rgb_slot = '0;
				pixels_done++;
				if (final_pix)
					dec_phase = PH_DONE;
				return 1'b1;
			end
			default:
				return 1'b0;
		endcase
	endfunction

	// one request, sent in bursts with random gaps unless the sender is held steady
	task automatic send_item(input logic [7:0] d, input logic sof, input logic eof);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 24);
			if (!sender_steady) begin
				gap = $urandom_range(1, 5);
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		data_byte <= d;
		start_of_file <= sof;
		end_of_file <= eof;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		requests_sent++;
		if (sof || eof || dec_phase == PH_MAGIC2 || dec_phase == PH_SKIP ||
				dec_phase == PH_NUM || dec_phase == PH_PIXELS)
			live_items++;
		if (decode_byte(d, sof, eof))
			pending_results.push_back(predicted);
	endtask

	task automatic wait_for_results();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [7:0] random_blank();
		case ($urandom_range(0, 5))
			0: return 8'd9;
			1: return 8'd10;
			2: return 8'd11;
			3: return 8'd12;
			4: return 8'd13;
			default: return 8'd32;
		endcase
	endfunction

	task automatic put_comment();
		logic [7:0] c;
		file_buf.push_back(CHAR_HASH);
		repeat ($urandom_range(0, 5)) begin
			c = 8'($urandom_range(0, 255));
			file_buf.push_back((c == CHAR_LF) ? CHAR_SP : c);
		end
		file_buf.push_back(CHAR_LF);
	endtask

	task automatic put_gap(input bit may_be_empty);
		int unsigned n;
		n = may_be_empty ? $urandom_range(0, 2) : $urandom_range(1, 3);
		repeat (n) begin
			if ($urandom_range(0, 3) == 0)
				put_comment();
			else
				file_buf.push_back(random_blank());
		end
	endtask

	task automatic put_number(input int unsigned v);
		string digits;
		int    k;
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 2)) file_buf.push_back(CHAR_ZERO);
		digits = $sformatf("%0d", v);
		for (k = 0; k < digits.len(); k++)
			file_buf.push_back(digits[k]);
	endtask

	// separator is a single blank when sep_ok, otherwise a '#' or some other byte
	task automatic put_header(input int unsigned w, input int unsigned h, input int unsigned mv,
			input bit sep_ok);
		logic [7:0] c;
		file_buf.push_back(CHAR_P);
		file_buf.push_back(CHAR_6);
		put_gap(1'b1);
		put_number(w);
		put_gap(1'b0);
		put_number(h);
		put_gap(1'b0);
		put_number(mv);
		if (sep_ok) begin
			file_buf.push_back(random_blank());
		end else if ($urandom_range(0, 1) == 0) begin
			file_buf.push_back(CHAR_HASH);
		end else begin
			do c = 8'($urandom_range(0, 255)); while (blank_char(c) || decimal_char(c));
			file_buf.push_back(c);
		end
	endtask

	task automatic send_file();
		int k;
		for (k = 0; k < file_buf.size(); k++)
			send_item(file_buf[k], k == 0, 1'b0);
		file_buf.delete();
		files_sent++;
	endtask

	function automatic int unsigned pick_side();
		case ($urandom_range(0, 7))
			0: return 63;
			1: return 65;
			2: return 0;
			3: return 65535;
			4: return 1234567;
			5: return $urandom_range(1, 300);
			default: return IMAGE_SIDE;
		endcase
	endfunction

	function automatic int unsigned pick_maxval();
		case ($urandom_range(0, 6))
			0: return 254;
			1: return 256;
			2: return 0;
			3: return 99999;
			4: return $urandom_range(1, 1000);
			default: return 255;
		endcase
	endfunction

	task automatic test_special_cases();
		send_item(8'h41, 1'b0, 1'b0);        // nothing started yet
		send_item(8'h00, 1'b0, 1'b1);        // end of stream while idle
		send_item(8'h00, 1'b1, 1'b0);        // bad first magic byte
		send_item(8'hFF, 1'b0, 1'b0);        // dropped after the error
		send_item(CHAR_P, 1'b1, 1'b1);       // start and end together, end wins
		send_item(CHAR_P, 1'b1, 1'b0);
		send_item(8'h35, 1'b0, 1'b0);        // bad second magic byte
		send_item(CHAR_P, 1'b1, 1'b0);
		send_item(CHAR_6, 1'b0, 1'b0);
		send_item(8'h80, 1'b0, 1'b1);        // cut short inside the header
		send_item(CHAR_P, 1'b1, 1'b0);
		send_item(CHAR_6, 1'b0, 1'b0);
		send_item(CHAR_HASH, 1'b0, 1'b0);
		send_item(8'h21, 1'b0, 1'b0);        // still inside the comment
		send_item(CHAR_LF, 1'b0, 1'b0);
		send_item(8'h21, 1'b0, 1'b0);        // junk where a number should start
		send_item(CHAR_P, 1'b1, 1'b0);
		send_item(CHAR_6, 1'b0, 1'b0);
		repeat (6) send_item(8'h39, 1'b0, 1'b0);  // width saturates
		send_item(CHAR_P, 1'b1, 1'b0);       // restart mid-header
		send_item(8'h00, 1'b0, 1'b1);
	endtask

	// one complete image, with the receiver blocked for a long stretch part way through
	task automatic test_full_image();
		int p;
		put_header(IMAGE_SIDE, IMAGE_SIDE, 255, 1'b1);
		send_file();
		for (p = 0; p < 3 * IMAGE_SIDE * IMAGE_SIDE; p++) begin
			if (p == 900) begin
				sender_steady = 1'b1;
				long_hold_req = 1'b1;
			end
			if (p == 1800)
				sender_steady = 1'b0;
			if (p < 3)
				send_item(8'h00, 1'b0, 1'b0);
			else if (p < 6)
				send_item(8'hFF, 1'b0, 1'b0);
			else
				send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
		end
		repeat (4) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);  // trailing bytes
		send_item(8'h00, 1'b0, 1'b1);
	endtask

	task automatic test_random_files();
		file_kind_t  kind;
		tail_t       tail;
		int unsigned goal;
		int unsigned pos;
		int unsigned hdr_len;
		goal = live_items + RANDOM_ITEMS;
		while (live_items < goal) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: kind = FK_GOOD;
				4: kind = FK_SIZE;
				5: kind = FK_NOSEP;
				6: kind = FK_CORRUPT;
				7, 8: kind = FK_CUT;
				default: kind = FK_NOISE;
			endcase
			tail = tail_t'($urandom_range(0, 3));
			if (kind == FK_NOISE) begin
				if ($urandom_range(0, 1) == 0) begin
					send_item(CHAR_P, 1'b1, 1'b0);
					send_item(CHAR_6, 1'b0, 1'b0);
				end
				repeat ($urandom_range(3, 20))
					send_item(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0,
						$urandom_range(0, 11) == 0);
			end else begin
				case (kind)
					FK_SIZE: put_header(pick_side(), pick_side(), pick_maxval(), 1'b1);
					FK_NOSEP: put_header(IMAGE_SIDE, IMAGE_SIDE, 255, 1'b0);
					default: put_header(IMAGE_SIDE, IMAGE_SIDE, 255, 1'b1);
				endcase
				hdr_len = file_buf.size();
				repeat ((kind == FK_GOOD) ? $urandom_range(0, 40) : $urandom_range(0, 6))
					file_buf.push_back(8'($urandom_range(0, 255)));
				if (kind == FK_CORRUPT) begin
					pos = $urandom_range(0, hdr_len - 1);
					file_buf[pos] = 8'($urandom_range(0, 255));
				end
				if (kind == FK_CUT) begin
					pos = $urandom_range(1, file_buf.size());
					while (file_buf.size() > pos) void'(file_buf.pop_back());
					tail = TAIL_EOF;
				end
				send_file();
			end
			case (tail)
				TAIL_EOF: send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
				TAIL_EOF_SOF: send_item(8'($urandom_range(0, 255)), 1'b1, 1'b1);
				TAIL_STRAY: begin
					send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
					repeat ($urandom_range(1, 3))
						send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
				end
				default: ;
			endcase
		end
	endtask

	// receiver stall pattern, plus one long hold-off when asked
	initial begin : rx_stall
		rx_mode_t    mode;
		int unsigned mode_left;
		int unsigned hold_left;
		mode = RX_FREE;
		mode_left = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_left != 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold_left = LONG_HOLD;
				out_stall <= 1'b1;
			end else begin
				if (mode_left == 0) begin
					mode = rx_mode_t'($urandom_range(0, 2));
					mode_left = $urandom_range(10, 150);
				end
				mode_left--;
				case (mode)
					RX_COIN: out_stall <= 1'($urandom_range(0, 1));
					RX_BUSY: out_stall <= ($urandom_range(0, 3) != 0);
					default: out_stall <= 1'b0;
				endcase
			end
		end
	end

	always @(posedge clk) begin : result_check
		decoded_t got;
		decoded_t want;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			got.status = status;
			got.red = red;
			got.green = green;
			got.blue = blue;
			got.luma = luma;
			got.index = pixel_index;
			got.last = last_pixel;
			if (pending_results.size() == 0) begin
				if (mismatch_count < MAX_REPORTS)
					$display("[%0d] unexpected result status %0d index %0d",
						cycle_count, got.status, got.index);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				if (want.status < 6)
					status_seen[want.status]++;
				if (got.status !== want.status || got.red !== want.red ||
						got.green !== want.green || got.blue !== want.blue ||
						got.luma !== want.luma || got.index !== want.index ||
						got.last !== want.last) begin
					if (mismatch_count < MAX_REPORTS) begin
						$display("[%0d] mismatch exp st=%0d rgb=%h/%h/%h y=%h idx=%0d last=%b",
							cycle_count, want.status, want.red, want.green, want.blue,
							want.luma, want.index, want.last);
						$display("[%0d]          got st=%0d rgb=%h/%h/%h y=%h idx=%0d last=%b",
							cycle_count, got.status, got.red, got.green, got.blue,
							got.luma, got.index, got.last);
					end
					mismatch_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (in_valid && in_stall)
			input_held++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				pending_results.size());
			$display("FAILED: results differ");
			$finish;
		end
	end

	initial begin
		int unsigned fail_total;
		dec_phase = PH_IDLE;
		clear_header();
		repeat (4) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		@(posedge clk);
		test_special_cases();
		wait_for_results();
		test_full_image();
		wait_for_results();
		test_random_files();
		wait_for_results();
		repeat (8) @(posedge clk);
		fail_total = mismatch_count + pending_results.size();
		$display("sent %0d requests in %0d files; checked %0d pixels and %0d error codes",
			requests_sent, files_sent, status_seen[ST_PIXEL],
			status_seen[ST_MAGIC] + status_seen[ST_MALFORMED] + status_seen[ST_NOSEP] +
			status_seen[ST_SIZE] + status_seen[ST_TRUNC]);
		$display("input held off for %0d cycles, %0d mismatches", input_held, mismatch_count);
		if (fail_total == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
